FILE: design/fpa_pkg.sv
// Shared action codes and field widths for the fixed-point ALU.
`default_nettype none
package fpa_pkg;
  localparam int ACT_W  = 4;
  localparam int DATA_W = 32;

  typedef logic [ACT_W-1:0] action_t;
  typedef logic signed [DATA_W-1:0] data_t;

  localparam action_t ACT_ADD  = 4'd0;
  localparam action_t ACT_SUB  = 4'd1;
  localparam action_t ACT_MUL  = 4'd2;
  localparam action_t ACT_DIV  = 4'd3;
  localparam action_t ACT_MIN  = 4'd4;
  localparam action_t ACT_MAX  = 4'd5;
  localparam action_t ACT_CMP  = 4'd6;
  localparam action_t ACT_INC  = 4'd7;
  localparam action_t ACT_DEC  = 4'd8;
  localparam action_t ACT_FINT = 4'd9;
  localparam action_t ACT_TINT = 4'd10;
endpackage
`default_nettype wire

FILE: design/fpa_if.sv
// Valid/ready channel interfaces for operation beats and result beats.
`default_nettype none
interface fpa_in_if;
  logic            valid;
  logic            ready;
  fpa_pkg::action_t action;
  fpa_pkg::data_t   operand_a;
  fpa_pkg::data_t   operand_b;
  modport source (output valid, action, operand_a, operand_b, input ready);
  modport sink (input valid, action, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if;
  logic           valid;
  logic           ready;
  fpa_pkg::data_t result_value;
  logic           less_flag;
  logic           equal_flag;
  logic           greater_flag;
  logic           divide_by_zero;
  modport source (output valid, result_value, less_flag, equal_flag, greater_flag,
                  divide_by_zero, input ready);
  modport sink (input valid, result_value, less_flag, equal_flag, greater_flag,
                divide_by_zero, output ready);
endinterface
`default_nettype wire

FILE: design/fixed_point_alu_core.sv
// Top level of the pipelined signed fixed-point ALU.
// Operation beats enter on in_bus (action, operand_a, operand_b) and one result
// beat per operation leaves on out_bus, in order. Both channels use valid/ready.
// The pipeline has FRAC_BITS + 35 register stages: an input register, one stage
// for the compare, simple results and the 32x32 multiply, one stage per
// quotient bit of the restoring divider (32 + FRAC_BITS of them), and an output
// register. Throughput is one beat per cycle while out_bus is ready; the
// divider's one-bit-per-stage chain sets the depth. Each stage holds its
// beat while the stage after it is full and stalled, so bubbles collapse
// and a new beat is taken whenever any stage ahead has room, also while a
// finished result waits on out_bus. A stalled receiver therefore holds the
// result steady and stops the pipeline only once it is full. Synchronous
// active-low reset empties the pipeline. Results wrap to the narrower of
// WORD_BITS and 32 bits and are sign extended.
`default_nettype none
module fixed_point_alu_core #(
  parameter int FRAC_BITS = 8,
  parameter int WORD_BITS = 32
) (
  input  wire  clk,
  input  wire  rst_n,
  fpa_in_if.sink    in_bus,
  fpa_out_if.source out_bus
);
  import fpa_pkg::*;

  localparam int DIVW  = DATA_W + FRAC_BITS;
  localparam int NS    = DIVW + 2;
  localparam int RES_W = (WORD_BITS < DATA_W) ? WORD_BITS : DATA_W;

  typedef struct packed {
    action_t             act;
    logic [DATA_W-1:0]   a;
    logic [DATA_W-1:0]   b;
    logic [DATA_W-1:0]   res;
    logic                lt;
    logic                eq;
    logic                gt;
    logic                neg;
    logic [DATA_W-1:0]   dvsr;
    logic [DATA_W-1:0]   rem;
    logic [DIVW-1:0]     quo;
  } stage_t;

  stage_t            st_r   [NS+1];
  stage_t            st_nxt [NS+1];
  logic   [NS:0]     v_r;
  logic   [NS+1:0]   en;

  logic signed [2*DATA_W-1:0] prod;
  logic        [DATA_W-1:0]   abs_a;
  logic        [DATA_W-1:0]   abs_b;
  logic        [DATA_W-1:0]   div_q;
  logic        [DATA_W-1:0]   fin;
  logic        [DATA_W:0]     rs     [NS+1];
  logic        [DATA_W:0]     rsub   [NS+1];

  always_comb begin
    en[NS+1] = out_bus.ready;
    for (int i = NS; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_bus.ready = en[0];

  assign prod  = $signed(st_r[0].a) * $signed(st_r[0].b);
  assign abs_a = st_r[0].a[DATA_W-1] ? (~st_r[0].a + 1'b1) : st_r[0].a;
  assign abs_b = st_r[0].b[DATA_W-1] ? (~st_r[0].b + 1'b1) : st_r[0].b;

  always_comb begin
    st_nxt[0]           = st_r[0];
    st_nxt[0].act       = in_bus.action;
    st_nxt[0].a         = in_bus.operand_a;
    st_nxt[0].b         = in_bus.operand_b;

    st_nxt[1]      = st_r[0];
    st_nxt[1].lt   = $signed(st_r[0].a) < $signed(st_r[0].b);
    st_nxt[1].eq   = st_r[0].a == st_r[0].b;
    st_nxt[1].gt   = $signed(st_r[0].a) > $signed(st_r[0].b);
    st_nxt[1].neg  = st_r[0].a[DATA_W-1] ^ st_r[0].b[DATA_W-1];
    st_nxt[1].dvsr = abs_b;
    st_nxt[1].rem  = '0;
    st_nxt[1].quo  = {abs_a, {FRAC_BITS{1'b0}}};
    unique case (st_r[0].act)
      ACT_ADD:  st_nxt[1].res = st_r[0].a + st_r[0].b;
      ACT_SUB:  st_nxt[1].res = st_r[0].a - st_r[0].b;
      ACT_MUL:  st_nxt[1].res = prod[FRAC_BITS+DATA_W-1:FRAC_BITS];
      ACT_MIN:  st_nxt[1].res = ($signed(st_r[0].a) < $signed(st_r[0].b)) ?
                                st_r[0].a : st_r[0].b;
      ACT_MAX:  st_nxt[1].res = ($signed(st_r[0].a) > $signed(st_r[0].b)) ?
                                st_r[0].a : st_r[0].b;
      ACT_INC:  st_nxt[1].res = st_r[0].a + 1'b1;
      ACT_DEC:  st_nxt[1].res = st_r[0].a - 1'b1;
      ACT_FINT: st_nxt[1].res = st_r[0].a << FRAC_BITS;
      ACT_TINT: st_nxt[1].res = $signed(st_r[0].a) >>> FRAC_BITS;
      default:  st_nxt[1].res = '0;
    endcase

    for (int k = 0; k <= NS; k++) begin
      rs[k]   = '0;
      rsub[k] = '0;
    end
    for (int k = 2; k <= DIVW + 1; k++) begin
      st_nxt[k] = st_r[k-1];
      rs[k]     = {st_r[k-1].rem, st_r[k-1].quo[DIVW-1]};
      rsub[k]   = rs[k] - {1'b0, st_r[k-1].dvsr};
      if (rs[k] >= {1'b0, st_r[k-1].dvsr}) begin
        st_nxt[k].rem = rsub[k][DATA_W-1:0];
        st_nxt[k].quo = {st_r[k-1].quo[DIVW-2:0], 1'b1};
      end else begin
        st_nxt[k].rem = rs[k][DATA_W-1:0];
        st_nxt[k].quo = {st_r[k-1].quo[DIVW-2:0], 1'b0};
      end
    end

    div_q = st_r[NS-1].neg ? (~st_r[NS-1].quo[DATA_W-1:0] + 1'b1) :
                             st_r[NS-1].quo[DATA_W-1:0];
    if (st_r[NS-1].act == ACT_DIV) begin
      fin = (st_r[NS-1].dvsr == '0) ? '0 : div_q;
    end else begin
      fin = st_r[NS-1].res;
    end
    st_nxt[NS] = st_r[NS-1];
    for (int i = 0; i < DATA_W; i++) begin
      st_nxt[NS].res[i] = (i < RES_W) ? fin[i] : fin[RES_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_bus.valid;
      end
      for (int i = 1; i <= NS; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i <= NS; i++) begin
      if (en[i]) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  assign out_bus.valid          = v_r[NS];
  assign out_bus.result_value   = st_r[NS].res;
  assign out_bus.less_flag      = st_r[NS].lt;
  assign out_bus.equal_flag     = st_r[NS].eq;
  assign out_bus.greater_flag   = st_r[NS].gt;
  assign out_bus.divide_by_zero = (st_r[NS].act == ACT_DIV) && (st_r[NS].dvsr == '0);

  a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> $onehot({out_bus.less_flag, out_bus.equal_flag,
                               out_bus.greater_flag}))
    else $error("comparison flags are not exactly one hot");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.divide_by_zero) |-> (out_bus.result_value == '0))
    else $error("divide by zero beat carries a nonzero result");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && !out_bus.ready) |=> (out_bus.valid && $stable(st_r[NS])))
    else $error("stalled result beat changed");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r && !out_bus.ready) |-> !in_bus.ready)
    else $error("full pipeline took a beat while stalled");
endmodule
`default_nettype wire

FILE: tb/fixed_point_alu_core_tb.sv
// Self-checking testbench for the fixed-point ALU: directed and random operation beats, predicted results.
`default_nettype none
module fixed_point_alu_core_tb;
  import fpa_pkg::*;

  localparam int FRAC = 8;
  localparam int LATENCY = FRAC + 35;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    action_t action;
    data_t   operand_a;
    data_t   operand_b;
  } alu_op_t;

  typedef struct packed {
    data_t result_value;
    logic  less_flag;
    logic  equal_flag;
    logic  greater_flag;
    logic  divide_by_zero;
  } alu_res_t;

  logic clk;
  logic rst_n;
  fpa_in_if  in_bus ();
  fpa_out_if out_bus ();

  fixed_point_alu_core #(.FRAC_BITS(FRAC), .WORD_BITS(32)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus.sink),
    .out_bus(out_bus.source)
  );

  alu_op_t  pending_ops[$];
  alu_res_t expected_results[$];
  int       mismatch_count = 0;
  int       idle_cycles;
  bit       hold_sender;
  int       burst_left;
  int       gap_left;
  int       stall_phase;

  function automatic alu_res_t compute_alu(alu_op_t op);
    alu_res_t r;
    logic signed [63:0] wa;
    logic signed [63:0] wb;
    logic signed [63:0] wide;
    wa = op.operand_a;
    wb = op.operand_b;
    wide = 0;
    r.divide_by_zero = 1'b0;
    case (op.action)
      ACT_ADD:  wide = wa + wb;
      ACT_SUB:  wide = wa - wb;
      ACT_MUL:  wide = (wa * wb) >>> FRAC;
      ACT_DIV: begin
        if (wb == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          wide = (wa <<< FRAC) / wb;
        end
      end
      ACT_MIN:  wide = (wa < wb) ? wa : wb;
      ACT_MAX:  wide = (wa > wb) ? wa : wb;
      ACT_CMP:  wide = 0;
      ACT_INC:  wide = wa + 1;
      ACT_DEC:  wide = wa - 1;
      ACT_FINT: wide = wa <<< FRAC;
      ACT_TINT: wide = wa >>> FRAC;
      default:  wide = 0;
    endcase
    r.result_value = wide[31:0];
    r.less_flag = op.operand_a < op.operand_b;
    r.equal_flag = op.operand_a == op.operand_b;
    r.greater_flag = op.operand_a > op.operand_b;
    return r;
  endfunction

  function automatic data_t pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3: return $signed($urandom_range(0, 1024)) - 512;
      4: return $signed({{16{1'b0}}, 16'($urandom)}) - 32768;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_op(action_t act, data_t a, data_t b);
    pending_ops.push_back('{act, a, b});
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (in_bus.valid && !in_bus.ready) begin
    end else if (hold_sender || pending_ops.size() == 0) begin
      in_bus.valid <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_bus.valid <= 1'b0;
    end else begin
      in_bus.valid <= 1'b1;
      {in_bus.action, in_bus.operand_a, in_bus.operand_b} <= pending_ops.pop_front();
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 30);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  always @(posedge clk) begin
    if (in_bus.valid && in_bus.ready && rst_n) begin
      expected_results.push_back(compute_alu('{in_bus.action, in_bus.operand_a,
                                               in_bus.operand_b}));
    end
  end

  always @(posedge clk) begin
    alu_res_t got;
    alu_res_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase[9:8] == 2'd0) begin
        out_bus.ready <= 1'b1;
      end else if (stall_phase[9:8] == 2'd1) begin
        out_bus.ready <= (stall_phase % 7) < 4;
      end else begin
        out_bus.ready <= $urandom_range(0, 2) != 0;
      end
      if (out_bus.valid && out_bus.ready) begin
        got = '{out_bus.result_value, out_bus.less_flag, out_bus.equal_flag,
                out_bus.greater_flag, out_bus.divide_by_zero};
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result beat %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("result beat: expected %h (a %0d) actual %h (a %0d)",
                       want, want.result_value, got, got.result_value);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("fixed_point_alu_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    action_t act;
    hold_sender = 0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    queue_op(ACT_ADD, 32'sh7fffffff, 1);
    queue_op(ACT_SUB, 32'sh80000000, 1);
    queue_op(ACT_MUL, 32'sh7fffffff, 32'sh7fffffff);
    queue_op(ACT_MUL, 32'sh80000000, 32'sh80000000);
    queue_op(ACT_MUL, -3, 5);
    queue_op(ACT_DIV, 32'sh12345678, 0);
    queue_op(ACT_DIV, 32'sh80000000, -1);
    queue_op(ACT_DIV, -1000, 3);
    queue_op(ACT_DIV, 32'sh7fffffff, 1);
    queue_op(ACT_MIN, 42, 42);
    queue_op(ACT_MAX, -7, -7);
    queue_op(ACT_MIN, 32'sh80000000, 32'sh7fffffff);
    queue_op(ACT_MAX, 32'sh80000000, 32'sh7fffffff);
    queue_op(ACT_CMP, 5, 9);
    queue_op(ACT_INC, 32'sh7fffffff, 0);
    queue_op(ACT_DEC, 32'sh80000000, 0);
    queue_op(ACT_FINT, 32'sh00ffffff, 1);
    queue_op(ACT_FINT, -1, 1);
    queue_op(ACT_TINT, 32'sh80000000, -1);
    queue_op(ACT_TINT, -1, 32'shffffffff);
    queue_op(4'd11, 3, 3);
    queue_op(4'd15, -1, 32'sh7fffffff);

    wait (pending_ops.size() == 0);
    hold_sender = 1;
    wait (!in_bus.valid);
    wait (expected_results.size() == 0);
    hold_sender = 0;

    repeat (700) begin
      act = ($urandom_range(0, 19) == 0) ? action_t'($urandom_range(11, 15))
                                         : action_t'($urandom_range(0, 10));
      queue_op(act, pick_operand(), ($urandom_range(0, 15) == 0) ? 0 : pick_operand());
    end
    wait (pending_ops.size() == 0 && !in_bus.valid);
    wait (expected_results.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("fixed_point_alu_core: match");
    end else begin
      $display("fixed_point_alu_core: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire
